// ===== hdl/imfhf_pkg.sv =====
// Shared widths and codes for the interval mean fire heat flux core.
// No dependencies.
package imfhf_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int FLUX_BITS_DEF = 24;
    localparam int DUR_BITS      = 24;

    typedef enum logic [1:0] {
        MODE_ZERO  = 2'd0,
        MODE_NOM   = 2'd1,
        MODE_SCALE = 2'd2
    } t_mode;

    localparam logic ST_OK      = 1'b0;
    localparam logic ST_NOMATCH = 1'b1;

endpackage

// ===== hdl/imfhf_div.sv =====
// Pipelined scaling divider: floor(flux * num / den) for num <= den, one beat per cycle.
// Uses imfhf_pkg for nothing but shares its width conventions; instantiated by the core.
module imfhf_div #(
    parameter int TB = 32,
    parameter int FB = 24
) (
    input  logic          i_clk,
    input  logic [FB-1:0] i_flux,
    input  logic [TB-1:0] i_num,
    input  logic [TB-1:0] i_den,
    output logic [FB-1:0] o_q
);
    localparam int PW = FB + TB;

    logic [PW-1:0] r_prod;
    logic [TB-1:0] r_den0;

    always_ff @(posedge i_clk) begin
        r_prod <= PW'(i_flux) * PW'(i_num);
        r_den0 <= i_den;
    end

    logic [TB-1:0] r_rem [1:FB];
    logic [FB-1:0] r_low [1:FB];
    logic [FB-1:0] r_q   [1:FB];
    logic [TB-1:0] r_den [1:FB];

    for (genvar k = 0; k < FB; k++) begin : g_stage
        logic [TB-1:0] c_rem;
        logic [FB-1:0] c_low;
        logic [FB-1:0] c_q;
        logic [TB-1:0] c_den;
        logic [TB:0]   t;
        logic [TB:0]   d;
        logic          ge;
        if (k == 0) begin : g_first
            assign c_rem = r_prod[PW-1:FB];
            assign c_low = r_prod[FB-1:0];
            assign c_q   = '0;
            assign c_den = r_den0;
        end else begin : g_next
            assign c_rem = r_rem[k];
            assign c_low = r_low[k];
            assign c_q   = r_q[k];
            assign c_den = r_den[k];
        end
        assign t  = {c_rem, c_low[FB-1]};
        assign ge = (t >= {1'b0, c_den});
        assign d  = t - {1'b0, c_den};
        always_ff @(posedge i_clk) begin
            r_rem[k+1] <= ge ? d[TB-1:0] : t[TB-1:0];
            r_low[k+1] <= {c_low[FB-2:0], 1'b0};
            r_q[k+1]   <= {c_q[FB-2:0], ge};
            r_den[k+1] <= c_den;
        end
    end

    assign o_q = r_q[FB];

endmodule

// ===== hdl/interval_mean_fire_heat_flux_core.sv =====
// Interval mean fire heat flux core: top level, phase timing and case selection.
// Depends on imfhf_pkg and imfhf_div.
// One cell beat is taken every clock cycle and busy never rises. Each result appears after
// the input, phase, case and divider registers and the output register, marked by o_strobe
// for one cycle. The restoring divider resolves one quotient bit per pipeline stage. The
// receiver cannot stall, so results must be captured in the cycle they are shown.
module interval_mean_fire_heat_flux_core #(
    parameter int TIME_BITS = imfhf_pkg::TIME_BITS_DEF,
    parameter int FLUX_BITS = imfhf_pkg::FLUX_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [TIME_BITS-1:0]   i_window_begin,
    input  logic signed [TIME_BITS-1:0]   i_window_end,
    input  logic signed [TIME_BITS-1:0]   i_arrival_time,
    input  logic [imfhf_pkg::DUR_BITS-1:0] i_evaporation_delay,
    input  logic [imfhf_pkg::DUR_BITS-1:0] i_residence_duration,
    input  logic [imfhf_pkg::DUR_BITS-1:0] i_burn_duration,
    input  logic [FLUX_BITS-1:0]          i_flaming_flux,
    input  logic [FLUX_BITS-1:0]          i_smoldering_flux,
    output logic                          o_strobe,
    output logic [FLUX_BITS-1:0]          o_mean_flaming,
    output logic [FLUX_BITS-1:0]          o_mean_smoldering,
    output logic [FLUX_BITS:0]            o_mean_total,
    output logic                          o_status
);
    import imfhf_pkg::*;

    localparam int TB  = TIME_BITS;
    localparam int FB  = FLUX_BITS;
    localparam int TW  = ((TB > DUR_BITS) ? TB : DUR_BITS) + 3;
    localparam int LAT = FB + 6;

    assign busy = 1'b0;

    // Stage 1: input capture.
    logic                 r1_v;
    logic signed [TB-1:0] r1_bt, r1_et, r1_at;
    logic [DUR_BITS-1:0]  r1_evap, r1_res, r1_burn;
    logic [FB-1:0]        r1_ff, r1_fs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_bt   <= i_window_begin;
        r1_et   <= i_window_end;
        r1_at   <= i_arrival_time;
        r1_evap <= i_evaporation_delay;
        r1_res  <= i_residence_duration;
        r1_burn <= i_burn_duration;
        r1_ff   <= i_flaming_flux;
        r1_fs   <= i_smoldering_flux;
    end

    // Stage 2: effective start and window length.
    logic                 r2_v;
    logic signed [TW-1:0] r2_a, r2_den, r2_bt, r2_et, r2_res, r2_burn;
    logic                 r2_eq;
    logic [FB-1:0]        r2_ff, r2_fs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_a    <= TW'(r1_at) + $signed({{(TW-DUR_BITS){1'b0}}, r1_evap});
        r2_den  <= TW'(r1_et) - TW'(r1_bt);
        r2_eq   <= (r1_bt == r1_et);
        r2_bt   <= TW'(r1_bt);
        r2_et   <= TW'(r1_et);
        r2_res  <= $signed({{(TW-DUR_BITS){1'b0}}, r1_res});
        r2_burn <= $signed({{(TW-DUR_BITS){1'b0}}, r1_burn});
        r2_ff   <= r1_ff;
        r2_fs   <= r1_fs;
    end

    // Stage 3: phase ends.
    logic                 r3_v;
    logic signed [TW-1:0] r3_a, r3_r, r3_b, r3_den, r3_bt, r3_et, r3_res, r3_bmr;
    logic                 r3_eq;
    logic [FB-1:0]        r3_ff, r3_fs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_a   <= r2_a;
        r3_r   <= r2_a + r2_res;
        r3_b   <= r2_a + r2_burn;
        r3_den <= r2_den;
        r3_bt  <= r2_bt;
        r3_et  <= r2_et;
        r3_res <= r2_res;
        r3_bmr <= r2_burn - r2_res;
        r3_eq  <= r2_eq;
        r3_ff  <= r2_ff;
        r3_fs  <= r2_fs;
    end

    // Stage 4: case selection.
    t_mode                n_mf, n_ms;
    logic signed [TW-1:0] n_numf, n_nums;
    logic                 n_st;

    always_comb begin
        n_mf   = MODE_ZERO;
        n_ms   = MODE_ZERO;
        n_numf = '0;
        n_nums = '0;
        n_st   = ST_OK;
        if (r3_eq) begin
            if (r3_bt < r3_a) begin
                n_mf = MODE_ZERO;
            end else if (r3_bt < r3_r) begin
                n_mf = MODE_NOM;
            end else if (r3_bt < r3_b) begin
                n_ms = MODE_NOM;
            end
        end else if (r3_et < r3_a || r3_bt > r3_b) begin
            n_mf = MODE_ZERO;
        end else if (r3_bt < r3_a) begin
            n_mf = MODE_SCALE;
            if (r3_et <= r3_r) begin
                n_numf = r3_et - r3_a;
            end else begin
                n_numf = r3_res;
                n_ms   = MODE_SCALE;
                n_nums = (r3_et <= r3_b) ? (r3_et - r3_r) : r3_bmr;
            end
        end else if (r3_bt <= r3_r) begin
            if (r3_et <= r3_r) begin
                n_mf = MODE_NOM;
            end else begin
                n_mf   = MODE_SCALE;
                n_numf = r3_r - r3_bt;
                n_ms   = MODE_SCALE;
                n_nums = (r3_et <= r3_b) ? (r3_et - r3_r) : r3_bmr;
            end
        end else if (r3_bt <= r3_b) begin
            if (r3_et <= r3_b) begin
                n_ms = MODE_NOM;
            end else begin
                n_ms   = MODE_SCALE;
                n_nums = r3_b - r3_bt;
            end
        end else begin
            n_st = ST_NOMATCH;
        end
    end

    logic                 r4_v;
    t_mode                r4_mf, r4_ms;
    logic signed [TW-1:0] r4_numf, r4_nums, r4_den;
    logic                 r4_st;
    logic [FB-1:0]        r4_ff, r4_fs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_mf   <= n_mf;
        r4_ms   <= n_ms;
        r4_numf <= n_numf;
        r4_nums <= n_nums;
        r4_den  <= r3_den;
        r4_st   <= n_st;
        r4_ff   <= r3_ff;
        r4_fs   <= r3_fs;
    end

    // Clamp overlaps to the window length and feed the dividers.
    logic          c_den_pos;
    logic [TB-1:0] c_numf, c_nums, c_den;
    t_mode         c_mf, c_ms;

    always_comb begin
        c_den_pos = (r4_den > 0);
        c_den     = r4_den[TB-1:0];
        if (r4_numf < 0) begin
            c_numf = '0;
        end else if (r4_numf > r4_den) begin
            c_numf = c_den;
        end else begin
            c_numf = r4_numf[TB-1:0];
        end
        if (r4_nums < 0) begin
            c_nums = '0;
        end else if (r4_nums > r4_den) begin
            c_nums = c_den;
        end else begin
            c_nums = r4_nums[TB-1:0];
        end
        c_mf = (r4_mf == MODE_SCALE && !c_den_pos) ? MODE_ZERO : r4_mf;
        c_ms = (r4_ms == MODE_SCALE && !c_den_pos) ? MODE_ZERO : r4_ms;
    end

    logic [FB-1:0] w_qf, w_qs;

    imfhf_div #(.TB(TB), .FB(FB)) u_div_flaming (
        .i_clk  (i_clk),
        .i_flux (r4_ff),
        .i_num  (c_numf),
        .i_den  (c_den),
        .o_q    (w_qf)
    );

    imfhf_div #(.TB(TB), .FB(FB)) u_div_smoldering (
        .i_clk  (i_clk),
        .i_flux (r4_fs),
        .i_num  (c_nums),
        .i_den  (c_den),
        .o_q    (w_qs)
    );

    // Side information travels alongside the divider stages.
    logic          r_sv  [0:FB];
    t_mode         r_smf [0:FB];
    t_mode         r_sms [0:FB];
    logic [FB-1:0] r_sff [0:FB];
    logic [FB-1:0] r_sfs [0:FB];
    logic          r_sst [0:FB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= FB; k++) begin
                r_sv[k] <= 1'b0;
            end
        end else begin
            r_sv[0] <= r4_v;
            for (int k = 1; k <= FB; k++) begin
                r_sv[k] <= r_sv[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_smf[0] <= c_mf;
        r_sms[0] <= c_ms;
        r_sff[0] <= r4_ff;
        r_sfs[0] <= r4_fs;
        r_sst[0] <= r4_st;
        for (int k = 1; k <= FB; k++) begin
            r_smf[k] <= r_smf[k-1];
            r_sms[k] <= r_sms[k-1];
            r_sff[k] <= r_sff[k-1];
            r_sfs[k] <= r_sfs[k-1];
            r_sst[k] <= r_sst[k-1];
        end
    end

    // Output register.
    logic [FB-1:0] n_mean_f, n_mean_s;

    always_comb begin
        case (r_smf[FB])
            MODE_NOM:   n_mean_f = r_sff[FB];
            MODE_SCALE: n_mean_f = w_qf;
            default:    n_mean_f = '0;
        endcase
        case (r_sms[FB])
            MODE_NOM:   n_mean_s = r_sfs[FB];
            MODE_SCALE: n_mean_s = w_qs;
            default:    n_mean_s = '0;
        endcase
    end

    logic          r_out_v;
    logic [FB-1:0] r_out_f, r_out_s;
    logic [FB:0]   r_out_t;
    logic          r_out_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= r_sv[FB];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_f  <= n_mean_f;
        r_out_s  <= n_mean_s;
        r_out_t  <= (FB+1)'(n_mean_f) + (FB+1)'(n_mean_s);
        r_out_st <= r_sst[FB];
    end

    assign o_strobe          = r_out_v;
    assign o_mean_flaming    = r_out_f;
    assign o_mean_smoldering = r_out_s;
    assign o_mean_total      = r_out_t;
    assign o_status          = r_out_st;

    // Every accepted beat produces exactly one result, shown on o_strobe after the pipeline.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_strobe)
        else $error("result strobe missing after accepted beat");

    a_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_mean_total == ((FB+1)'(o_mean_flaming) + (FB+1)'(o_mean_smoldering))))
        else $error("total flux does not match phase sum");

    a_nomatch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status) |-> (o_mean_flaming == '0 && o_mean_smoldering == '0))
        else $error("nonzero flux with no-match status");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r4_v == 1'b0) |=> (r_sv[0] == 1'b0))
        else $error("divider side valid raised without an item");

endmodule
